// ----- src/olane_pkg.sv -----
// ----------------------------------------------------------------------------
// Overlay lane allocator package
// Shared sizes, codes and control types for the lane allocator modules.
// ----------------------------------------------------------------------------
package olane_pkg;

    // Lanes per style class table.
    localparam int LANES  = 128;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W  = $clog2(LANES + 1);
    localparam int DEPTH  = 3 * LANES;
    localparam int ADDR_W = $clog2(DEPTH);

    // Fixed field widths.
    localparam int WIN_W   = 12;
    localparam int LH_W    = 8;
    localparam int VT_W    = 16;
    localparam int TIME_W  = 32;
    localparam int ITEM_W  = 12;
    localparam int YOUT_W  = 14;
    localparam int LOUT_W  = 8;
    localparam int WAIT_W  = 17;
    localparam int ACC_W   = 13;
    localparam int PROD_W  = LANE_W + LH_W;
    localparam int POS_W   = 17;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // Timing and placement constants.
    localparam int BASE_WAIT_MS = 500;
    localparam int MS_PER_S     = 1000;
    localparam int HEADER_PX    = 50;
    localparam int CLAMP_PX     = 5;
    // Idle times at or above 2**SMALL_IDLE_W seconds always beat the longest wait.
    localparam int SMALL_IDLE_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_MODE    = 2'd3;

    // Style classes.
    localparam logic [1:0] CLS_MOVING = 2'd0;
    localparam logic [1:0] CLS_TOP    = 2'd1;
    localparam logic [1:0] CLS_BOTTOM = 2'd2;

    // Stage enables for the position unit.
    typedef struct packed {
        logic mul_en;
        logic y_en;
    } pos_ctrl_t;

    // First table entry of a style class; the unused class code shares the moving table.
    function automatic logic [ADDR_W-1:0] table_base(input logic [1:0] cls);
        logic [ADDR_W-1:0] base;
        case (cls)
            CLS_TOP:    base = ADDR_W'(LANES);
            CLS_BOTTOM: base = ADDR_W'(2 * LANES);
            default:    base = '0;
        endcase
        return base;
    endfunction

endpackage

// ----- src/olane_stamp_ram.sv -----
// ----------------------------------------------------------------------------
// Lane stamp memory
// One write port and one registered read port holding last-use times.
// ----------------------------------------------------------------------------
module olane_stamp_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [olane_pkg::ADDR_W-1:0] waddr,
    input  logic [olane_pkg::TIME_W-1:0] wdata,
    input  logic [olane_pkg::ADDR_W-1:0] raddr,
    output logic [olane_pkg::TIME_W-1:0] rdata
);
    import olane_pkg::*;

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/olane_lane_cmp.sv -----
// ----------------------------------------------------------------------------
// Lane compare unit
// Decides whether one stored stamp marks a free lane or a new oldest lane.
// ----------------------------------------------------------------------------
module olane_lane_cmp (
    input  logic [olane_pkg::TIME_W-1:0] now,
    input  logic [olane_pkg::TIME_W-1:0] stamp,
    input  logic [olane_pkg::TIME_W-1:0] oldest,
    input  logic [olane_pkg::WAIT_W-1:0] wait_ms,
    output logic                         free,
    output logic                         older
);
    import olane_pkg::*;

    logic [TIME_W:0]   idle;
    logic              big_idle;
    logic [WAIT_W-1:0] small_ms;

    // The idle time is a signed difference; a stamp in the future never frees a lane.
    assign idle     = {1'b0, now} - {1'b0, stamp};
    assign big_idle = |idle[TIME_W-1:SMALL_IDLE_W];
    assign small_ms = WAIT_W'(idle[SMALL_IDLE_W-1:0]) * WAIT_W'(MS_PER_S);
    assign free     = !idle[TIME_W] && (big_idle || (small_ms > wait_ms));
    assign older    = oldest > stamp;

endmodule

// ----- src/olane_pos_unit.sv -----
// ----------------------------------------------------------------------------
// Position unit
// Turns a chosen lane into a clamped vertical position over two stages.
// ----------------------------------------------------------------------------
module olane_pos_unit (
    input  logic                          aclk,
    input  olane_pkg::pos_ctrl_t          ctrl,
    input  logic [olane_pkg::LANE_W-1:0]  lane,
    input  logic [olane_pkg::LH_W-1:0]    lane_height,
    input  logic [olane_pkg::WIN_W-1:0]   view_height,
    input  logic [olane_pkg::ITEM_W-1:0]  item_height,
    input  logic                          bottom,
    input  logic                          sched,
    input  logic                          normal_mode,
    input  logic                          media_mode,
    output logic [olane_pkg::YOUT_W-1:0]  y_out
);
    import olane_pkg::*;

    logic [PROD_W-1:0]       prod_reg;
    logic signed [POS_W-1:0] y_reg;
    logic signed [POS_W-1:0] y_next;
    logic [LH_W+1:0]         footer;
    logic [POS_W-1:0]        header;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] y_final;

    assign footer = normal_mode ? '0 : 10'(({2'b0, lane_height} * 10'd3) >> 1);
    assign header = (!normal_mode && !media_mode) ? POS_W'(HEADER_PX) : '0;

    always_comb begin
        if (!sched) begin
            y_next = '0;
        end else if (bottom) begin
            y_next = $signed(POS_W'(view_height) - POS_W'(prod_reg)
                             - POS_W'({lane_height, 1'b0}) - POS_W'(footer));
        end else begin
            y_next = $signed(POS_W'(prod_reg) + header);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(lane) * PROD_W'(lane_height);
        end
        if (ctrl.y_en) begin
            y_reg <= y_next;
        end
    end

    assign max_y   = $signed(POS_W'(view_height)) - $signed(POS_W'(item_height));
    assign y_final = (y_reg > max_y - POS_W'(CLAMP_PX)) ? max_y : y_reg;
    assign y_out   = y_final[YOUT_W-1:0];

endmodule

// ----- src/overlay_lane_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Overlay lane allocator core
// Picks a display lane for one text item and returns its vertical position.
// ----------------------------------------------------------------------------
// After reset the block first zeroes its 384-entry stamp memory, one entry per
// clock, and takes no request until that pass is done; configuration writes
// are taken at any time. A request then reads up to min(view height / lane
// height, 128) lanes, stopping at the first free lane. The scan reads one
// stored stamp per clock through the single read port of the stamp memory,
// and the shared compare unit judges that stamp in the same clock. Then come
// stamping the chosen lane, the lane-times-height multiply, the position
// formula and the clamp, in that order. When the window is too small to
// scan, a request skips the scan and the stamp write. The finished result
// sits in an output register, so the block returns to idle even while the
// result has not yet been taken, unless an older result still blocks that
// register.
module overlay_lane_allocator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: visible_ms[15:0], now_seconds[47:16], item_height[59:48], zero pad.
    input  logic [olane_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: style_class[1:0].
    input  logic [olane_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: y_position[13:0], lane_index[21:14], zero pad.
    output logic [olane_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: scheduled[0].
    output logic                              m_tuser,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [olane_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [olane_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import olane_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_STAMP = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_YRAW  = 7'b0100000,
        ST_CLAMP = 7'b1000000
    } state_t;

    // Configuration registers.
    logic [WIN_W-1:0] win_reg;
    logic [LH_W-1:0]  lh_reg;
    logic             normal_reg;
    logic             media_reg;

    // Control state.
    state_t           st_reg, st_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;

    // Per-request working registers.
    logic [1:0]        cls_reg, cls_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LANE_W-1:0] idx_reg, idx_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TIME_W-1:0] oldest_reg, oldest_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              sched_reg, sched_next;

    // Result register.
    logic [YOUT_W-1:0] y_out_reg, y_out_next;
    logic [LOUT_W-1:0] lane_out_reg, lane_out_next;
    logic              sched_out_reg, sched_out_next;

    // Datapath signals.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [TIME_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [TIME_W-1:0] stamp;
    logic              lane_free;
    logic              lane_older;
    pos_ctrl_t         pos_ctrl;
    logic [YOUT_W-1:0] y_final;

    // Request fields.
    logic [VT_W-1:0]   in_vt;
    logic [TIME_W-1:0] in_now;
    logic [ITEM_W-1:0] in_item;
    logic [1:0]        in_cls;
    logic [CNT_W-1:0]  nxt_idx;
    logic [ACC_W-1:0]  acc_step;

    assign in_vt   = s_tdata[VT_W-1:0];
    assign in_now  = s_tdata[VT_W+TIME_W-1:VT_W];
    assign in_item = s_tdata[VT_W+TIME_W+ITEM_W-1:VT_W+TIME_W];
    assign in_cls  = s_tuser;

    // Configuration is always taken; the register file is tiny.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= WIN_W'(480);
            lh_reg     <= LH_W'(30);
            normal_reg <= 1'b1;
            media_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_HEIGHT: win_reg    <= cfg_data[WIN_W-1:0];
                CFG_LANE_HEIGHT:   lh_reg     <= cfg_data[LH_W-1:0];
                CFG_NORMAL_MODE:   normal_reg <= cfg_data[0];
                CFG_MEDIA_MODE:    media_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The lane after the one now being judged, and the running height sum
    // that tells whether it still fits inside the window.
    assign nxt_idx  = CNT_W'(idx_reg) + CNT_W'(1);
    assign acc_step = acc_reg + ACC_W'(lh_reg);

    always_comb begin
        st_next        = st_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cls_next       = cls_reg;
        wait_next      = wait_reg;
        now_next       = now_reg;
        item_next      = item_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        oldest_next    = oldest_reg;
        lane_next      = lane_reg;
        sched_next     = sched_reg;
        y_out_next     = y_out_reg;
        lane_out_next  = lane_out_reg;
        sched_out_next = sched_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = base_reg + ADDR_W'(lane_reg);
        ram_wdata      = now_reg;
        ram_raddr      = base_reg + ADDR_W'(nxt_idx[LANE_W-1:0]);
        pos_ctrl       = '0;

        case (st_reg)
            ST_CLEAR: begin
                // Zero every stamp once after reset.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    st_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                // Lane zero of the incoming class is fetched while the request is taken.
                ram_raddr = table_base(in_cls);
                if (s_tvalid) begin
                    cls_next    = in_cls;
                    wait_next   = WAIT_W'(BASE_WAIT_MS) +
                                  ((in_cls == CLS_MOVING) ? WAIT_W'(in_vt >> 1) : WAIT_W'(in_vt));
                    now_next    = in_now;
                    item_next   = in_item;
                    base_next   = table_base(in_cls);
                    idx_next    = '0;
                    acc_next    = ACC_W'(lh_reg);
                    oldest_next = in_now;
                    lane_next   = '0;
                    // A window no taller than two lanes, or a zero lane height, is not scanned.
                    if (lh_reg != '0 && {1'b0, win_reg} > {4'b0, lh_reg, 1'b0}) begin
                        sched_next = 1'b1;
                        st_next    = ST_SCAN;
                    end else begin
                        sched_next = 1'b0;
                        st_next    = ST_MUL;
                    end
                end
            end
            ST_SCAN: begin
                if (lane_free) begin
                    lane_next = idx_reg;
                    st_next   = ST_STAMP;
                end else begin
                    if (lane_older) begin
                        oldest_next = stamp;
                        lane_next   = idx_reg;
                    end
                    if (nxt_idx < CNT_W'(LANES) && acc_step <= {1'b0, win_reg}) begin
                        idx_next = nxt_idx[LANE_W-1:0];
                        acc_next = acc_step;
                    end else begin
                        st_next = ST_STAMP;
                    end
                end
            end
            ST_STAMP: begin
                ram_we  = 1'b1;
                st_next = ST_MUL;
            end
            ST_MUL: begin
                pos_ctrl.mul_en = 1'b1;
                st_next         = ST_YRAW;
            end
            ST_YRAW: begin
                pos_ctrl.y_en = 1'b1;
                st_next       = ST_CLAMP;
            end
            ST_CLAMP: begin
                // Wait here only while an older result still holds the output register.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    y_out_next     = y_final;
                    lane_out_next  = LOUT_W'(lane_reg);
                    sched_out_next = sched_reg;
                    st_next        = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg       <= cls_next;
        wait_reg      <= wait_next;
        now_reg       <= now_next;
        item_reg      <= item_next;
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        acc_reg       <= acc_next;
        oldest_reg    <= oldest_next;
        lane_reg      <= lane_next;
        sched_reg     <= sched_next;
        y_out_reg     <= y_out_next;
        lane_out_reg  <= lane_out_next;
        sched_out_reg <= sched_out_next;
    end

    olane_stamp_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (stamp)
    );

    olane_lane_cmp u_cmp (
        .now     (now_reg),
        .stamp   (stamp),
        .oldest  (oldest_reg),
        .wait_ms (wait_reg),
        .free    (lane_free),
        .older   (lane_older)
    );

    olane_pos_unit u_pos (
        .aclk          (aclk),
        .ctrl          (pos_ctrl),
        .lane          (lane_reg),
        .lane_height   (lh_reg),
        .view_height   (win_reg),
        .item_height   (item_reg),
        .bottom        (cls_reg == CLS_BOTTOM),
        .sched         (sched_reg),
        .normal_mode   (normal_reg),
        .media_mode    (media_reg),
        .y_out         (y_final)
    );

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - YOUT_W - LOUT_W){1'b0}}, lane_out_reg, y_out_reg};
    assign m_tuser  = sched_out_reg;

    // The lane being judged always lies inside the window.
    a_scan_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SCAN |-> acc_reg <= {1'b0, win_reg})
        else $error("scanned lane lies outside the window");

    // The best lane so far is never ahead of the lane being judged.
    a_lane_order: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SCAN |-> lane_reg <= idx_reg)
        else $error("chosen lane ahead of scan position");

    // A stamp write after the clearing pass stays inside the request's own table.
    a_stamp_table: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && st_reg != ST_CLEAR |->
            ram_waddr >= base_reg && {1'b0, ram_waddr} < {1'b0, base_reg} + (ADDR_W+1)'(LANES))
        else $error("stamp written outside its class table");

    // An unscheduled result always reports lane zero.
    a_unsched_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[YOUT_W+LOUT_W-1:YOUT_W] == '0)
        else $error("unscheduled result carries a lane");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Overlay lane allocator core testbench
// Streams placement requests through the core under a series of view and lane
// settings, predicts each placement from a private copy of the stamp tables
// and checks every returned result field by field.
// ----------------------------------------------------------------------------
module testbench;

    import olane_pkg::*;

    // The longest stretch without any transfer that a correct run can show is
    // the stamp clearing pass after reset or the long receiver hold-off; this
    // limit lies well above both.
    localparam int STUCK_LIMIT  = 3000;
    // Length of the receiver hold-off that fills the core and stalls its input.
    localparam int HOLD_CYCLES  = 600;
    // A full 128-lane scan plus the position stages, with some margin.
    localparam int SETTLE_TIME  = 150;

    typedef struct packed {
        logic [1:0]  style_class;
        logic [15:0] visible_ms;
        logic [31:0] now_s;
        logic [11:0] item_h;
    } lane_req_t;

    typedef struct packed {
        logic [13:0] y_pos;
        logic [7:0]  lane;
        logic        sched;
    } placement_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [S_TUSER_W-1:0]    s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DAT_W-1:0]    cfg_data  = '0;

    // Requests waiting to be offered, and placements waiting to come back.
    lane_req_t  pending_reqs[$];
    placement_t placements_due[$];

    // Private copy of the core's registers and per-class lane stamp tables.
    logic [11:0] view_h      = 12'd480;
    logic [7:0]  lane_h      = 8'd30;
    logic        normal_mode = 1'b1;
    logic        media_mode  = 1'b0;
    logic [31:0] stamp_mem [0:DEPTH-1];

    // Handshake bookkeeping shared between the driver, sink and monitor.
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   req_gap   = 0;
    int   res_gap   = 0;
    int   hold_left = 0;
    int   reqs_pushed   = 0;
    int   reqs_sent     = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    bit   src_idle_en   = 1'b0;
    bit   snk_idle_en   = 1'b0;
    int   errors        = 0;
    int   stuck_cycles  = 0;
    logic [31:0] clock_s = 32'd0;

    overlay_lane_allocator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Works out where one request lands and stamps the chosen lane in the
    // private table. The scan stops at the first lane that has been idle
    // longer than the wait time; otherwise it keeps the lane with the oldest
    // stamp that lies strictly in the past, lowest lane on ties, or lane 0.
    function automatic placement_t place_item(input logic [1:0] style,
                                              input logic [15:0] visible,
                                              input logic [31:0] now,
                                              input logic [11:0] item_h);
        placement_t  res;
        int          win, lh, y, maxy, n_lanes, base, lane, k, footer, header;
        longint      now_l, stamp_l, wait_ms;
        logic [31:0] oldest, stamp;
        win   = int'(view_h);
        lh    = int'(lane_h);
        y     = 0;
        lane  = 0;
        res.sched = 1'b0;
        if (lh != 0 && win > 2 * lh) begin
            // Class three has no table of its own and shares the moving one.
            base = (style == CLS_TOP) ? LANES : ((style == CLS_BOTTOM) ? 2 * LANES : 0);
            // Moving items only need half their visible time to clear a lane.
            wait_ms = (style == CLS_MOVING) ? longint'(visible / 2) : longint'(visible);
            wait_ms = wait_ms + BASE_WAIT_MS;
            n_lanes = win / lh;
            if (n_lanes > LANES)
                n_lanes = LANES;
            now_l  = longint'(now);
            oldest = now;
            for (k = 0; k < n_lanes; k++) begin
                stamp   = stamp_mem[base + k];
                stamp_l = longint'(stamp);
                // A stamp ahead of now gives a negative idle time, never free.
                if ((now_l - stamp_l) * MS_PER_S > wait_ms) begin
                    lane = k;
                    break;
                end else if (oldest > stamp) begin
                    oldest = stamp;
                    lane   = k;
                end
            end
            stamp_mem[base + lane] = now;
            res.sched = 1'b1;
            if (style == CLS_BOTTOM) begin
                footer = normal_mode ? 0 : (lh * 3) / 2;
                y = win - (lane + 2) * lh - footer;
            end else begin
                header = (!normal_mode && !media_mode) ? HEADER_PX : 0;
                y = lane * lh + header;
            end
        end
        // The clamp applies even when the window was too small to schedule.
        maxy = win - int'(item_h);
        if (y > maxy - CLAMP_PX)
            y = maxy;
        res.y_pos = y[13:0];
        res.lane  = lane[7:0];
        return res;
    endfunction

    // Request driver. A request stays on the bus until its transfer; the
    // gap drawn when it was loaded is then spent with tvalid low before the
    // next request goes out. With no gap the next one follows back to back.
    always @(negedge aclk) begin : drive_requests
        lane_req_t nxt;
        if (s_tvalid && !req_taken) begin
            // Still waiting for the core to take the current request.
        end else if (req_gap != 0) begin
            s_tvalid <= 1'b0;
            req_gap  <= req_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            // tdata: visible ms, now seconds, item height from bit 0 up.
            s_tdata  <= {4'd0, nxt.item_h, nxt.now_s, nxt.visible_ms};
            s_tuser  <= nxt.style_class;
            req_gap  <= src_idle_en ? $urandom_range(0, 8) : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result sink. After each transfer it may pause with tready low. On a
    // hold request it drops tready for a long stretch so that the output
    // register and the pipeline fill and the core backs up its input.
    always @(negedge aclk) begin : accept_results
        int gap;
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (res_taken) begin
            gap = snk_idle_en ? $urandom_range(0, 8) : 0;
            res_gap  <= gap;
            m_tready <= (gap == 0);
        end else if (res_gap > 1) begin
            res_gap  <= res_gap - 1;
            m_tready <= 1'b0;
        end else begin
            res_gap  <= 0;
            m_tready <= 1'b1;
        end
    end

    // Monitor. Everything is sampled at the rising edge: a request transfer
    // queues its predicted placement, a result transfer is checked against
    // the oldest one waiting. The watchdog ends the run if no transfer of
    // any kind happens for too long.
    always @(posedge aclk) begin : check_results
        placement_t want;
        req_taken <= s_tvalid && s_tready;
        res_taken <= m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (placements_due.size() == 0) begin
                $error("result transfer with no placement pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                errors++;
            end else begin
                want = placements_due.pop_front();
                if (m_tdata[13:0] !== want.y_pos) begin
                    $error("y_position: expected %0d, actual %0d",
                           $signed(want.y_pos), $signed(m_tdata[13:0]));
                    errors++;
                end
                if (m_tdata[21:14] !== want.lane) begin
                    $error("lane_index: expected %0d, actual %0d", want.lane, m_tdata[21:14]);
                    errors++;
                end
                if (m_tuser !== want.sched) begin
                    $error("scheduled: expected %0d, actual %0d", want.sched, m_tuser);
                    errors++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            placements_due.push_back(place_item(s_tuser, s_tdata[15:0], s_tdata[47:16],
                                                s_tdata[59:48]));
            reqs_sent <= reqs_sent + 1;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no transfer for %0d cycles", STUCK_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // One register write over the configuration channel. The private copy
    // keeps only the bits that the register holds.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_WINDOW_HEIGHT: view_h = val;
            CFG_LANE_HEIGHT:   lane_h = val[7:0];
            CFG_NORMAL_MODE:   normal_mode = val[0];
            CFG_MEDIA_MODE:    media_mode = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_config(input int win, input int lh, input bit npm, input bit mtm);
        write_reg(CFG_WINDOW_HEIGHT, CFG_DAT_W'(win));
        write_reg(CFG_LANE_HEIGHT, CFG_DAT_W'(lh));
        write_reg(CFG_NORMAL_MODE, CFG_DAT_W'(npm));
        write_reg(CFG_MEDIA_MODE, CFG_DAT_W'(mtm));
    endtask

    task automatic push_item(input logic [1:0] style, input logic [15:0] visible,
                             input logic [31:0] now, input logic [11:0] item_h);
        pending_reqs.push_back('{style, visible, now, item_h});
        reqs_pushed++;
    endtask

    // Random request. The clock mostly creeps forward so that lanes fill and
    // free up again; now and then it jumps ahead, steps back so that stamps
    // lie in the future, or lands anywhere in the 32-bit range.
    task automatic push_random();
        int          r;
        logic [1:0]  style;
        logic [15:0] visible;
        logic [11:0] item_h;
        r = $urandom_range(0, 99);
        if (r < 60)
            clock_s = clock_s + $urandom_range(0, 1);
        else if (r < 85)
            clock_s = clock_s + $urandom_range(2, 5);
        else if (r < 92)
            clock_s = clock_s + $urandom_range(6, 100);
        else if (r < 97)
            clock_s = clock_s - $urandom_range(1, 10);
        else
            clock_s = $urandom;
        style   = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        visible = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(1, 3000));
        item_h  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, 80));
        push_item(style, visible, clock_s, item_h);
    endtask

    // Waits until every queued request has been taken and every placement
    // has come back, which leaves the core idle.
    task automatic drain();
        @(negedge aclk);
        while (reqs_sent != reqs_pushed || placements_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_random(input int n, input bit src_gaps, input bit snk_gaps);
        src_idle_en = src_gaps;
        snk_idle_en = snk_gaps;
        repeat (n)
            push_random();
        drain();
    endtask

    initial begin : stimulus
        int i, win, lh;
        for (i = 0; i < DEPTH; i++)
            stamp_mem[i] = '0;
        repeat (7)
            @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset settings: field extremes, every
        // class including the unused code, a stamp in the future, negative
        // and clamped positions.
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        push_item(CLS_MOVING, 16'd1, 32'd0, 12'd0);
        push_item(CLS_TOP, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF);
        push_item(CLS_BOTTOM, 16'd0, 32'd1, 12'd0);
        push_item(2'd3, 16'd1000, 32'd1, 12'd30);
        push_item(CLS_MOVING, 16'd200, 32'd5, 12'd20);
        push_item(CLS_MOVING, 16'd200, 32'd5, 12'd20);
        push_item(CLS_MOVING, 16'd200, 32'd5, 12'd20);
        push_item(CLS_MOVING, 16'd1200, 32'd6, 12'd20);
        push_item(CLS_TOP, 16'd10, 32'd3, 12'd10);
        push_item(CLS_TOP, 16'd10, 32'd3, 12'd10);
        push_item(CLS_BOTTOM, 16'd400, 32'd1, 12'd40);
        push_item(CLS_BOTTOM, 16'd400, 32'd1, 12'd40);
        push_item(CLS_BOTTOM, 16'd400, 32'd3, 12'd40);
        push_item(2'd3, 16'd499, 32'd7, 12'd455);
        push_item(CLS_MOVING, 16'd998, 32'd9, 12'd456);
        push_item(CLS_TOP, 16'hFFFF, 32'hFFFF_FFFE, 12'd0);
        clock_s = 32'd10;
        drain();

        // Tallest view with the thinnest lanes: the scan is capped at the
        // table size, and the header offset applies.
        write_config(4095, 1, 0, 0);
        run_random(110, 1, 1);

        // Thickest lanes with the header suppressed by the media mode.
        write_config(4095, 255, 0, 1);
        run_random(110, 0, 0);

        // A window exactly two lanes tall is too small to schedule. The
        // receiver holds off meanwhile so that the core backs up.
        write_config(60, 30, 1, 0);
        hold_requests++;
        run_random(90, 0, 1);

        // Zero window and zero lane height.
        write_config(0, 0, 0, 1);
        run_random(40, 1, 0);

        // One pixel above the limit leaves two lanes. The lane register is
        // written with its unused upper bits set, and the clock runs through
        // its wrap so that older stamps suddenly lie ahead of now.
        write_config(61, 30, 0, 0);
        write_reg(CFG_LANE_HEIGHT, 12'hA1E);
        clock_s = 32'hFFFF_FFE0;
        run_random(120, 1, 1);

        // Both offset suppressions on, with another long receiver hold-off.
        write_config(720, 24, 1, 1);
        hold_requests++;
        run_random(150, 1, 1);

        for (i = 0; i < 8; i++) begin
            win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 4095);
            lh  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
            write_config(win, lh, $urandom_range(0, 1), $urandom_range(0, 1));
            run_random(100, $urandom_range(0, 1), $urandom_range(0, 1));
        end

        repeat (SETTLE_TIME)
            @(posedge aclk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
